// ----- hdl/afcf_pkg.sv -----
// shared types and constants for the audio module command framer
package afcf_pkg;

    // input command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_PLAY  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_WAIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VOL  = 1'd1;

    localparam logic [15:0] BOOT_WAIT_RST = 16'd1500;
    localparam logic [4:0]  INIT_VOL_RST  = 5'd20;

    // frame bytes and opcodes
    localparam logic [7:0] FR_START = 8'h7E;
    localparam logic [7:0] FR_VER   = 8'hFF;
    localparam logic [7:0] FR_LEN   = 8'h06;
    localparam logic [7:0] FR_END   = 8'hEF;
    localparam logic [7:0] OP_VOL   = 8'h06;
    localparam logic [7:0] OP_STOP  = 8'h16;
    localparam logic [7:0] OP_PLAY  = 8'h03;

    localparam logic [15:0] TRACK_MAX = 16'd64;
    localparam logic [15:0] PAUSE_MS  = 16'd20;
    localparam logic [15:0] STEP_MS   = 16'd120;

    localparam logic [3:0] FRAME_LAST_IDX = 4'd9;

    localparam int NUM_PLAYERS_DEF = 8;
    localparam int JOB_Q_DEPTH_DEF = 4;

    // one unit of work for the back end: a play frame or a volume+stop pair
    typedef struct packed {
        logic       pair;
        logic [3:0] player;
        logic [7:0] param;
        logic       rdy;
    } t_job;

endpackage

// ----- hdl/afcf_if.sv -----
// channel interfaces: command words, frame byte words and register writes
interface afcf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  player;
    logic [15:0] track;
    modport source (output valid, cmd, player, track, input ready);
    modport sink (input valid, cmd, player, track, output ready);
endinterface

interface afcf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [3:0] dest_player;
    logic       last_byte;
    logic       all_ready;
    modport source (output valid, frame_byte, dest_player, last_byte, all_ready, input ready);
    modport sink (input valid, frame_byte, dest_player, last_byte, all_ready, output ready);
endinterface

interface afcf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [afcf_pkg::CFG_IDX_W-1:0]  index;
    logic [afcf_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/audio_module_command_framer_unit.sv -----
// top level of the audio module command framer
//
//  port     dir  word                                  handshake
//  i_cmd    in   cmd, player, track                    valid/ready
//  i_cfg    in   index, data (0 boot_wait_ms, 1 vol)   valid/ready, always ready
//  o_res    out  frame_byte, dest_player, last_byte,   valid/ready
//                all_ready
//
//  a command word is decoded combinationally; frame jobs go into a 4-entry queue
//  the back end sends one byte per cycle while o_res is not stalled: 10 bytes for play, 20 for an init step
//  i_cmd stalls only while the job queue is full; o_res stalls the back end, which can fill the queue
//  first byte passes the queue, the back-end job register and the output register
//  synchronous active-low reset clears sequencer, queue and output valid
module audio_module_command_framer_unit #(
    parameter int NUM_PLAYERS = afcf_pkg::NUM_PLAYERS_DEF,
    parameter int JOB_Q_DEPTH = afcf_pkg::JOB_Q_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    afcf_cmd_if.sink   i_cmd,
    afcf_cfg_if.sink   i_cfg,
    afcf_byte_if.source o_res
);

    logic           q_full, q_push, q_pop, q_valid;
    afcf_pkg::t_job front_job, q_job;

    afcf_front #(
        .NUM_PLAYERS(NUM_PLAYERS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_cmd.valid),
        .o_ready     (i_cmd.ready),
        .i_cmd       (i_cmd.cmd),
        .i_player    (i_cmd.player),
        .i_track     (i_cmd.track),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (front_job)
    );

    afcf_queue #(
        .DEPTH(JOB_Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    afcf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_job       (q_job),
        .o_pop         (q_pop),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_frame_byte  (o_res.frame_byte),
        .o_dest_player (o_res.dest_player),
        .o_last_byte   (o_res.last_byte),
        .o_all_ready   (o_res.all_ready)
    );

endmodule

// ----- hdl/afcf_front.sv -----
// front end: config registers, init sequencer state, command decode into jobs
module afcf_front #(
    parameter int NUM_PLAYERS = afcf_pkg::NUM_PLAYERS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [3:0]                      i_player,
    input  logic [15:0]                     i_track,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [afcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [afcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_q_full,
    output logic                            o_push,
    output afcf_pkg::t_job                  o_job
);

    logic [15:0] r_boot_wait;
    logic [4:0]  r_init_vol;
    logic        r_started, n_started;
    logic        r_rdy, n_rdy;
    logic [3:0]  r_stage, n_stage;
    logic [15:0] r_wait, n_wait;

    logic        accept;
    logic [15:0] wait_dec;
    logic [7:0]  track_clamped;

    assign o_ready     = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign wait_dec    = (r_wait != 16'd0) ? (r_wait - 16'd1) : 16'd0;

    always_comb begin
        if (i_track == 16'd0) begin
            track_clamped = 8'd1;
        end else if (i_track > afcf_pkg::TRACK_MAX) begin
            track_clamped = afcf_pkg::TRACK_MAX[7:0];
        end else begin
            track_clamped = i_track[7:0];
        end
    end

    always_comb begin
        n_started = r_started;
        n_rdy     = r_rdy;
        n_stage   = r_stage;
        n_wait    = r_wait;
        o_push    = 1'b0;
        o_job     = '{pair: 1'b0, player: i_player, param: track_clamped, rdy: r_rdy};
        if (accept) begin
            unique case (i_cmd)
                afcf_pkg::CMD_START: begin
                    n_started = 1'b1;
                    n_rdy     = 1'b0;
                    n_stage   = 4'd0;
                    n_wait    = r_boot_wait;
                end
                afcf_pkg::CMD_PLAY: begin
                    o_push = r_started && (32'(i_player) < NUM_PLAYERS);
                end
                afcf_pkg::CMD_TICK: begin
                    if (r_started && !r_rdy) begin
                        n_wait = wait_dec;
                        if (wait_dec == 16'd0) begin
                            if (r_stage == 4'd0) begin
                                n_stage = 4'd1;
                                n_wait  = afcf_pkg::PAUSE_MS;
                            end else if (32'(r_stage) - 32'd1 < NUM_PLAYERS) begin
                                o_push  = 1'b1;
                                o_job   = '{pair: 1'b1, player: r_stage - 4'd1,
                                            param: {3'd0, r_init_vol}, rdy: r_rdy};
                                n_stage = r_stage + 4'd1;
                                n_wait  = afcf_pkg::STEP_MS;
                            end else begin
                                n_rdy = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_wait <= afcf_pkg::BOOT_WAIT_RST;
            r_init_vol  <= afcf_pkg::INIT_VOL_RST;
            r_started   <= 1'b0;
            r_rdy       <= 1'b0;
            r_stage     <= 4'd0;
            r_wait      <= 16'd0;
        end else begin
            r_started <= n_started;
            r_rdy     <= n_rdy;
            r_stage   <= n_stage;
            r_wait    <= n_wait;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    afcf_pkg::REG_BOOT_WAIT: r_boot_wait <= i_cfg_data;
                    afcf_pkg::REG_INIT_VOL:  r_init_vol  <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- hdl/afcf_queue.sv -----
// small job queue between front and back end
module afcf_queue #(
    parameter int DEPTH = afcf_pkg::JOB_Q_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  afcf_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output afcf_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    afcf_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/afcf_back.sv -----
// back end: serializes jobs into frame bytes through an output register
module afcf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  afcf_pkg::t_job i_q_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_frame_byte,
    output logic [3:0]     o_dest_player,
    output logic           o_last_byte,
    output logic           o_all_ready
);

    afcf_pkg::t_job r_job;
    logic           r_busy;
    logic           r_second;
    logic [3:0]     r_idx;
    logic           r_ov;

    logic           out_load, emit, frame_end, job_end;
    logic [7:0]     op, lo, cur_byte;
    logic [15:0]    sum, chk;

    assign out_load  = !r_ov || i_ready;
    assign emit      = r_busy && out_load;
    assign frame_end = (r_idx == afcf_pkg::FRAME_LAST_IDX);
    assign job_end   = frame_end && (!r_job.pair || r_second);
    assign o_pop     = i_q_valid && (!r_busy || (emit && job_end));
    assign o_valid   = r_ov;

    always_comb begin
        if (!r_job.pair) begin
            op = afcf_pkg::OP_PLAY;
            lo = r_job.param;
        end else if (r_second) begin
            op = afcf_pkg::OP_STOP;
            lo = 8'd0;
        end else begin
            op = afcf_pkg::OP_VOL;
            lo = r_job.param;
        end
        // high parameter byte is always zero here
        sum = 16'(afcf_pkg::FR_VER) + 16'(afcf_pkg::FR_LEN) + 16'(op) + 16'(lo);
        chk = 16'd0 - sum;
        case (r_idx)
            4'd0:    cur_byte = afcf_pkg::FR_START;
            4'd1:    cur_byte = afcf_pkg::FR_VER;
            4'd2:    cur_byte = afcf_pkg::FR_LEN;
            4'd3:    cur_byte = op;
            4'd6:    cur_byte = lo;
            4'd7:    cur_byte = chk[15:8];
            4'd8:    cur_byte = chk[7:0];
            4'd9:    cur_byte = afcf_pkg::FR_END;
            default: cur_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_frame_byte  <= cur_byte;
            o_dest_player <= r_job.player;
            o_last_byte   <= job_end;
            o_all_ready   <= r_job.rdy;
        end
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
            r_idx    <= 4'd0;
            r_ov     <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (out_load) begin
                r_ov <= 1'b0;
            end
            if (emit) begin
                if (frame_end) begin
                    r_idx <= 4'd0;
                    if (job_end) begin
                        r_second <= 1'b0;
                        r_busy   <= o_pop;
                    end else begin
                        r_second <= 1'b1;
                    end
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end else if (o_pop) begin
                r_busy <= 1'b1;
            end
        end
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// testbench for the audio module command framer: command words in, checked frame bytes out

module testbench;

    localparam int NPLAYERS = afcf_pkg::NUM_PLAYERS_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_MAX = 17;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_MAX = 60;

    typedef struct packed {
        logic [7:0] fbyte;
        logic [3:0] dest;
        logic       last;
        logic       rdy;
    } t_frame_word;

    class frame_scoreboard;
        t_frame_word want_q[$];
        int          errors;
        logic [15:0] boot_wait;
        logic [4:0]  init_vol;
        bit          started;
        bit          all_rdy;
        logic [3:0]  stage;
        logic [15:0] wait_left;

        function new();
            boot_wait = afcf_pkg::BOOT_WAIT_RST;
            init_vol  = afcf_pkg::INIT_VOL_RST;
            started   = 1'b0;
            all_rdy   = 1'b0;
            stage     = 4'd0;
            wait_left = 16'd0;
            errors    = 0;
        endfunction

        task report(input string what);
            if (errors < REPORT_MAX) $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void write_reg(input logic [afcf_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] data);
            case (idx)
                afcf_pkg::REG_BOOT_WAIT: boot_wait = data;
                afcf_pkg::REG_INIT_VOL: init_vol = data[4:0];
                default: ;
            endcase
        endfunction

        // one 10-byte frame: 7E FF 06 op 00 hi lo chk_hi chk_lo EF
        function void push_frame(input logic [3:0] dest, input logic [7:0] op,
                                 input logic [15:0] param, input bit ends);
            logic [15:0] sum;
            logic [15:0] chk;
            logic [7:0]  fb[10];
            t_frame_word w;
            sum = {8'h00, afcf_pkg::FR_VER} + {8'h00, afcf_pkg::FR_LEN} + {8'h00, op}
                + {8'h00, param[15:8]} + {8'h00, param[7:0]};
            chk = 16'h0000 - sum;
            fb[0] = afcf_pkg::FR_START;
            fb[1] = afcf_pkg::FR_VER;
            fb[2] = afcf_pkg::FR_LEN;
            fb[3] = op;
            fb[4] = 8'h00;
            fb[5] = param[15:8];
            fb[6] = param[7:0];
            fb[7] = chk[15:8];
            fb[8] = chk[7:0];
            fb[9] = afcf_pkg::FR_END;
            for (int i = 0; i < 10; i++) begin
                w.fbyte = fb[i];
                w.dest  = dest;
                w.last  = ends && (i == 9);
                w.rdy   = all_rdy;
                want_q.push_back(w);
            end
        endfunction

        function void note_cmd(input logic [1:0] cmd, input logic [3:0] player,
                               input logic [15:0] track);
            logic [15:0] trk;
            case (cmd)
                afcf_pkg::CMD_START: begin
                    started   = 1'b1;
                    all_rdy   = 1'b0;
                    stage     = 4'd0;
                    wait_left = boot_wait;
                end
                afcf_pkg::CMD_PLAY: begin
                    if (started && player < NPLAYERS) begin
                        trk = track;
                        if (trk < 16'd1) trk = 16'd1;
                        if (trk > afcf_pkg::TRACK_MAX) trk = afcf_pkg::TRACK_MAX;
                        push_frame(player, afcf_pkg::OP_PLAY, trk, 1'b1);
                    end
                end
                afcf_pkg::CMD_TICK: begin
                    if (started && !all_rdy) begin
                        if (wait_left != 16'd0) wait_left--;
                        if (wait_left == 16'd0) begin
                            if (stage == 4'd0) begin
                                stage     = 4'd1;
                                wait_left = afcf_pkg::PAUSE_MS;
                            end else if (stage <= NPLAYERS) begin
                                push_frame(stage - 4'd1, afcf_pkg::OP_VOL, {11'd0, init_vol},
                                           1'b0);
                                push_frame(stage - 4'd1, afcf_pkg::OP_STOP, 16'd0, 1'b1);
                                stage     = stage + 4'd1;
                                wait_left = afcf_pkg::STEP_MS;
                            end else begin
                                all_rdy = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task check_word(input t_frame_word got);
            t_frame_word want;
            if (want_q.size() == 0) begin
                report($sformatf("byte %h for player %0d with none pending",
                                 got.fbyte, got.dest));
            end else begin
                want = want_q.pop_front();
                if (got.fbyte !== want.fbyte)
                    report($sformatf("frame_byte %h, want %h", got.fbyte, want.fbyte));
                if (got.dest !== want.dest)
                    report($sformatf("dest_player %0d, want %0d", got.dest, want.dest));
                if (got.last !== want.last)
                    report($sformatf("last_byte %b, want %b", got.last, want.last));
                if (got.rdy !== want.rdy)
                    report($sformatf("all_ready %b, want %b", got.rdy, want.rdy));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    afcf_cmd_if  cmd_ch ();
    afcf_cfg_if  cfg_ch ();
    afcf_byte_if res_ch ();

    audio_module_command_framer_unit #(
        .NUM_PLAYERS(NPLAYERS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .i_cfg  (cfg_ch),
        .o_res  (res_ch)
    );

    frame_scoreboard sb;
    bit tx_burst;
    bit rx_burst;
    int rx_hold;
    int cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check every accepted word, then draw the next stall
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            sb.check_word(t_frame_word'({res_ch.frame_byte, res_ch.dest_player,
                                         res_ch.last_byte, res_ch.all_ready}));
            rx_hold = rx_burst ? 0 : $urandom_range(0, HOLD_MAX);
            if ($urandom_range(0, 59) == 0) rx_burst = !rx_burst;
        end else if (rx_hold != 0) begin
            rx_hold--;
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= (rx_hold == 0);
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [3:0] player,
                            input logic [15:0] track);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, HOLD_MAX);
        @(negedge i_clk);
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.cmd    <= cmd;
        cmd_ch.player <= player;
        cmd_ch.track  <= track;
        do begin
            @(posedge i_clk);
        end while (cmd_ch.ready !== 1'b1);
        sb.note_cmd(cmd, player, track);
    endtask

    task automatic write_cfg(input logic [afcf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do begin
            @(posedge i_clk);
        end while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // drop valid, wait out every pending word, then give the block time to go quiet
    task automatic settle();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_track();
        int r;
        logic [15:0] edges[5];
        edges = '{16'd0, 16'd1, 16'd64, 16'd65, 16'hFFFF};
        r = $urandom_range(0, 3);
        if (r < 2) return 16'($urandom_range(0, 70));
        if (r == 2) return 16'($urandom);
        return edges[$urandom_range(0, 4)];
    endfunction

    function automatic logic [3:0] pick_player();
        if ($urandom_range(0, 9) < 7) return 4'($urandom_range(0, NPLAYERS - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic rand_item(input int start_pct, input int play_pct);
        int r;
        logic [1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < start_pct) cmd = afcf_pkg::CMD_START;
        else if (r < start_pct + 3) cmd = CMD_UNUSED;
        else if (r < start_pct + 3 + play_pct) cmd = afcf_pkg::CMD_PLAY;
        else cmd = afcf_pkg::CMD_TICK;
        send_cmd(cmd, 4'($urandom_range(0, 15))
                      & (cmd == afcf_pkg::CMD_PLAY ? pick_player() : 4'hF),
                 pick_track());
    endtask

    // one stretch of traffic at a given setting
    task automatic run_phase(input logic [15:0] boot, input logic [4:0] vol, input int n_items,
                             input int start_pct, input int play_pct);
        int n;
        settle();
        write_cfg(afcf_pkg::REG_BOOT_WAIT, boot);
        write_cfg(afcf_pkg::REG_INIT_VOL, {11'd0, vol});
        tx_burst = $urandom_range(0, 3) == 0;
        rx_burst = $urandom_range(0, 3) == 0;
        send_cmd(afcf_pkg::CMD_START, pick_player(), pick_track());
        n = 0;
        while (n < n_items) begin
            rand_item(start_pct, play_pct);
            n++;
            if ($urandom_range(0, 99) == 0) settle();
            if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        end
    endtask

    initial begin
        sb = new();
        i_rst_n       = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.cmd    = afcf_pkg::CMD_TICK;
        cmd_ch.player = 4'd0;
        cmd_ch.track  = 16'd0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = afcf_pkg::REG_BOOT_WAIT;
        cfg_ch.data   = 16'd0;
        res_ch.ready  = 1'b0;
        rx_hold       = 0;
        cycles        = 0;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // nothing happens before start
        send_cmd(afcf_pkg::CMD_TICK, 4'd0, 16'd0);
        send_cmd(afcf_pkg::CMD_PLAY, 4'd3, 16'd10);
        send_cmd(CMD_UNUSED, 4'hF, 16'hFFFF);
        // start at reset settings, then plays across track and player limits
        send_cmd(afcf_pkg::CMD_START, 4'd0, 16'd0);
        send_cmd(afcf_pkg::CMD_PLAY, 4'd0, 16'd0);
        send_cmd(afcf_pkg::CMD_PLAY, 4'(NPLAYERS - 1), 16'hFFFF);
        send_cmd(afcf_pkg::CMD_PLAY, 4'(NPLAYERS), 16'd5);
        send_cmd(afcf_pkg::CMD_PLAY, 4'hF, 16'd5);
        send_cmd(afcf_pkg::CMD_PLAY, 4'd2, 16'd64);
        send_cmd(afcf_pkg::CMD_PLAY, 4'd5, 16'd65);
        send_cmd(afcf_pkg::CMD_PLAY, 4'd1, 16'd1);
        send_cmd(afcf_pkg::CMD_PLAY, 4'd6, 16'h8000);
        send_cmd(afcf_pkg::CMD_TICK, 4'hA, 16'h5555);
        send_cmd(CMD_UNUSED, 4'd1, 16'd3);
        settle();
        // zero boot wait: first tick moves straight into the pause
        write_cfg(afcf_pkg::REG_BOOT_WAIT, 16'd0);
        write_cfg(afcf_pkg::REG_INIT_VOL, 16'd30);
        send_cmd(afcf_pkg::CMD_START, 4'd0, 16'd0);
        send_cmd(afcf_pkg::CMD_TICK, 4'd0, 16'd0);
        send_cmd(afcf_pkg::CMD_TICK, 4'd0, 16'd0);
        send_cmd(afcf_pkg::CMD_START, 4'd0, 16'd0);
        send_cmd(afcf_pkg::CMD_TICK, 4'd0, 16'd0);
        send_cmd(afcf_pkg::CMD_PLAY, 4'd4, 16'd33);

        // zero boot wait: pause, then the first init steps with plays in between
        run_phase(16'd0, 5'd30, 170, 0, 6);
        // boot wait never ends: plays only carry frames
        run_phase(16'hFFFF, 5'd0, 40, 2, 40);
        run_phase(16'd1, 5'($urandom_range(0, 30)), 50, 1, 10);
        run_phase(16'($urandom_range(0, 40)), 5'd15, 50, 1, 12);
        run_phase(16'd2, 5'd0, 40, 0, 8);

        settle();
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
